// ----- rtl/hlbc_pkg.sv -----
// Shared constants, types and helper functions for the hashed LRU buffer cache.
// Used by every module of the block; depends on nothing else.
package hlbc_pkg;

  localparam int BUCKETS   = 6;
  localparam int WAYS      = 5;
  localparam int COUNT_MAX = 255;

  localparam int NBUF     = BUCKETS * WAYS;
  localparam int IDX_W    = (NBUF > 1) ? $clog2(NBUF) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W    = $clog2(COUNT_MAX + 1);

  localparam int CMD_W    = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 2;

  localparam int CHUNK_W     = 8;
  localparam int CHUNKS      = BLK_W / CHUNK_W;
  localparam int CHUNK_CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int REM_W       = BKT_W + CHUNK_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_GET_WR,
    S_HREAD,
    S_RANK
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block;
    logic             valid;
    logic [CNT_W-1:0] count;
    logic [WAY_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } wr_req_t;

  // One step of the bucket remainder: (r * 2^CHUNK_W + chunk) mod BUCKETS,
  // reduced by a chain of conditional subtractions.
  function automatic logic [BKT_W-1:0] rem_chunk_step(input logic [BKT_W-1:0] r,
                                                      input logic [CHUNK_W-1:0] chunk);
    logic [REM_W-1:0] v;
    v = (REM_W'(r) << CHUNK_W) | REM_W'(chunk);
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v >= (REM_W'(BUCKETS) << i)) begin
        v = v - (REM_W'(BUCKETS) << i);
      end
    end
    return BKT_W'(v);
  endfunction

  // Way of a buffer handle, that is the handle modulo WAYS.
  function automatic logic [WAY_W-1:0] handle_way(input logic [HANDLE_W-1:0] h);
    logic [WAY_W:0] r;
    r = '0;
    for (int i = HANDLE_W - 1; i >= 0; i--) begin
      r = {r[WAY_W-1:0], h[i]};
      if (r >= (WAY_W + 1)'(WAYS)) begin
        r = r - (WAY_W + 1)'(WAYS);
      end
    end
    return r[WAY_W-1:0];
  endfunction

endpackage

// ----- rtl/hlbc_rem_unit.sv -----
// Iterative bucket remainder unit: block number modulo the bucket count,
// one byte per cycle, most significant byte first. Depends on hlbc_pkg.
module hlbc_rem_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hlbc_pkg::BLK_W-1:0]  block_number,
  output logic                        done,
  output logic [hlbc_pkg::BKT_W-1:0]  bucket
);

  logic                              run;
  logic [hlbc_pkg::CHUNK_CNT_W-1:0]  step;
  logic [hlbc_pkg::BLK_W-1:0]        sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == hlbc_pkg::CHUNK_CNT_W'(hlbc_pkg::CHUNKS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= block_number;
      bucket <= '0;
    end else if (run) begin
      bucket <= hlbc_pkg::rem_chunk_step(bucket,
                  sh[hlbc_pkg::BLK_W-1 -: hlbc_pkg::CHUNK_W]);
      sh     <= sh << hlbc_pkg::CHUNK_W;
    end
  end

endmodule

// ----- rtl/hlbc_tag_store.sv -----
// Per-buffer tag, valid, count and recency store with one read and one write port.
// Reset clears every entry and ranks each bucket's ways in way order. Depends on hlbc_pkg.
module hlbc_tag_store (
  input  logic                        clk,
  input  logic                        rst,
  input  hlbc_pkg::wr_req_t           wr,
  input  logic [hlbc_pkg::IDX_W-1:0]  rd_idx,
  output hlbc_pkg::entry_t            rd_ent
);

  hlbc_pkg::entry_t ent [hlbc_pkg::NBUF];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < hlbc_pkg::BUCKETS; b++) begin
        for (int w = 0; w < hlbc_pkg::WAYS; w++) begin
          ent[b * hlbc_pkg::WAYS + w] <= '{device: '0, block: '0, valid: 1'b0,
                                           count: '0, rank: hlbc_pkg::WAY_W'(w)};
        end
      end
    end else if (wr.en) begin
      ent[wr.idx] <= wr.ent;
    end
  end

  assign rd_ent = ent[rd_idx];

endmodule

// ----- rtl/hashed_lru_buffer_cache.sv -----
// Top level of the hashed LRU buffer cache tag engine: sequencer and result register.
// Depends on hlbc_pkg, hlbc_rem_unit and hlbc_tag_store.
//
// Requests enter on req_valid/req_stall with cmd, device, block_number and handle_in.
// An item is taken when req_valid is high and req_stall is low; one result per item
// leaves on rsp_valid/rsp_stall with status, handle_out, hit and needs_read.
// The block works on one item at a time and holds req_stall high until it is done.
// A get passes the block number through the remainder unit byte by byte, then
// reads one way of the bucket per cycle through the single store port and writes
// back the chosen entry once the result register is free.
// Pin, unpin and release read the entry named by handle_in directly; a release that
// drops the count to zero walks the bucket's ways once more to update the recency
// ranks, one way per cycle, the last way held until the result register is free.
// Results wait in an output register, so a new item may be taken while one result
// is held; a stalled receiver only holds the finishing cycle of the next item.
// Synchronous reset clears all tags, valid marks and counts, ranks each bucket's
// ways in way order and empties the result register; no item is pending afterward.
module hashed_lru_buffer_cache (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [hlbc_pkg::CMD_W-1:0]     cmd,
  input  logic [hlbc_pkg::DEV_W-1:0]     device,
  input  logic [hlbc_pkg::BLK_W-1:0]     block_number,
  input  logic [hlbc_pkg::HANDLE_W-1:0]  handle_in,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [hlbc_pkg::STATUS_W-1:0]  status,
  output logic [hlbc_pkg::HANDLE_W-1:0]  handle_out,
  output logic                           hit,
  output logic                           needs_read
);

  hlbc_pkg::state_t  state, state_next;

  logic [hlbc_pkg::CMD_W-1:0]     req_cmd;
  logic [hlbc_pkg::DEV_W-1:0]     req_device;
  logic [hlbc_pkg::BLK_W-1:0]     req_block;
  logic [hlbc_pkg::HANDLE_W-1:0]  req_handle;

  logic [hlbc_pkg::IDX_W-1:0]     base;
  logic [hlbc_pkg::WAY_W-1:0]     way;
  logic                           hit_found;
  logic [hlbc_pkg::IDX_W-1:0]     hit_idx;
  hlbc_pkg::entry_t               hit_ent;
  logic                           free_found;
  logic [hlbc_pkg::IDX_W-1:0]     free_idx;
  logic [hlbc_pkg::WAY_W-1:0]     free_rank;
  logic [hlbc_pkg::WAY_W-1:0]     mr_rank;

  logic                           rem_start;
  logic                           rem_done;
  logic [hlbc_pkg::BKT_W-1:0]     rem_bucket;

  hlbc_pkg::wr_req_t              wr;
  logic [hlbc_pkg::IDX_W-1:0]     rd_idx;
  hlbc_pkg::entry_t               rd_ent;

  logic                           slot_free;
  logic                           last_way;
  logic                           in_range;
  logic                           tag_match;
  logic                           go_rank;
  logic                           res_load;
  hlbc_pkg::status_t              res_status;
  logic [hlbc_pkg::HANDLE_W-1:0]  res_handle;
  logic                           res_hit;
  logic                           res_read;

  assign req_stall = (state != hlbc_pkg::S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign last_way  = (way == hlbc_pkg::WAY_W'(hlbc_pkg::WAYS - 1));
  assign in_range  = (int'(req_handle) < hlbc_pkg::NBUF);
  assign tag_match = (rd_ent.device == req_device) && (rd_ent.block == req_block);
  assign rem_start = (state == hlbc_pkg::S_IDLE) && req_valid &&
                     (hlbc_pkg::cmd_t'(cmd) == hlbc_pkg::CMD_GET);

  hlbc_rem_unit u_rem (
    .clk          (clk),
    .rst          (rst),
    .start        (rem_start),
    .block_number (block_number),
    .done         (rem_done),
    .bucket       (rem_bucket)
  );

  hlbc_tag_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hlbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    rd_idx     = '0;
    go_rank    = 1'b0;
    res_load   = 1'b0;
    res_status = hlbc_pkg::ST_OK;
    res_handle = '0;
    res_hit    = 1'b0;
    res_read   = 1'b0;
    unique case (state)
      hlbc_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = (hlbc_pkg::cmd_t'(cmd) == hlbc_pkg::CMD_GET) ?
                       hlbc_pkg::S_MOD : hlbc_pkg::S_HREAD;
        end
      end
      hlbc_pkg::S_MOD: begin
        if (rem_done) begin
          state_next = hlbc_pkg::S_SCAN;
        end
      end
      hlbc_pkg::S_SCAN: begin
        rd_idx = base + hlbc_pkg::IDX_W'(way);
        if (last_way) begin
          state_next = hlbc_pkg::S_GET_WR;
        end
      end
      hlbc_pkg::S_GET_WR: begin
        if (slot_free) begin
          state_next = hlbc_pkg::S_IDLE;
          res_load   = 1'b1;
          if (hit_found) begin
            res_hit    = 1'b1;
            res_handle = hlbc_pkg::HANDLE_W'(hit_idx);
            if (hit_ent.count >= hlbc_pkg::CNT_W'(hlbc_pkg::COUNT_MAX)) begin
              res_status = hlbc_pkg::ST_OVERFLOW;
            end else begin
              wr.en        = 1'b1;
              wr.idx       = hit_idx;
              wr.ent       = hit_ent;
              wr.ent.count = hit_ent.count + 1'b1;
              wr.ent.valid = 1'b1;
              res_read     = !hit_ent.valid;
            end
          end else if (free_found) begin
            wr.en      = 1'b1;
            wr.idx     = free_idx;
            wr.ent     = '{device: req_device, block: req_block, valid: 1'b1,
                           count: hlbc_pkg::CNT_W'(1), rank: free_rank};
            res_handle = hlbc_pkg::HANDLE_W'(free_idx);
            res_read   = 1'b1;
          end else begin
            res_status = hlbc_pkg::ST_NO_FREE;
          end
        end
      end
      hlbc_pkg::S_HREAD: begin
        rd_idx     = hlbc_pkg::IDX_W'(req_handle);
        res_handle = req_handle;
        if (!in_range) begin
          if (slot_free) begin
            state_next = hlbc_pkg::S_IDLE;
            res_load   = 1'b1;
            res_status = hlbc_pkg::ST_NO_FREE;
          end
        end else begin
          unique case (hlbc_pkg::cmd_t'(req_cmd))
            hlbc_pkg::CMD_PIN: begin
              if (slot_free) begin
                state_next = hlbc_pkg::S_IDLE;
                res_load   = 1'b1;
                if (rd_ent.count >= hlbc_pkg::CNT_W'(hlbc_pkg::COUNT_MAX)) begin
                  res_status = hlbc_pkg::ST_OVERFLOW;
                end else begin
                  wr.en        = 1'b1;
                  wr.idx       = rd_idx;
                  wr.ent       = rd_ent;
                  wr.ent.count = rd_ent.count + 1'b1;
                end
              end
            end
            hlbc_pkg::CMD_RELEASE, hlbc_pkg::CMD_UNPIN: begin
              if (rd_ent.count == '0) begin
                if (slot_free) begin
                  state_next = hlbc_pkg::S_IDLE;
                  res_load   = 1'b1;
                  res_status = hlbc_pkg::ST_UNDERFLOW;
                end
              end else if (hlbc_pkg::cmd_t'(req_cmd) == hlbc_pkg::CMD_RELEASE &&
                           rd_ent.count == hlbc_pkg::CNT_W'(1)) begin
                wr.en        = 1'b1;
                wr.idx       = rd_idx;
                wr.ent       = rd_ent;
                wr.ent.count = '0;
                go_rank      = 1'b1;
                state_next   = hlbc_pkg::S_RANK;
              end else if (slot_free) begin
                state_next   = hlbc_pkg::S_IDLE;
                res_load     = 1'b1;
                wr.en        = 1'b1;
                wr.idx       = rd_idx;
                wr.ent       = rd_ent;
                wr.ent.count = rd_ent.count - 1'b1;
              end
            end
            hlbc_pkg::CMD_GET: begin
              state_next = hlbc_pkg::S_IDLE;
            end
          endcase
        end
      end
      hlbc_pkg::S_RANK: begin
        rd_idx = base + hlbc_pkg::IDX_W'(way);
        if (!last_way || slot_free) begin
          wr.en  = 1'b1;
          wr.idx = rd_idx;
          wr.ent = rd_ent;
          if (rd_idx == hlbc_pkg::IDX_W'(req_handle)) begin
            wr.ent.rank = hlbc_pkg::WAY_W'(hlbc_pkg::WAYS - 1);
          end else if (rd_ent.rank > mr_rank) begin
            wr.ent.rank = rd_ent.rank - 1'b1;
          end
        end
        if (last_way && slot_free) begin
          state_next = hlbc_pkg::S_IDLE;
          res_load   = 1'b1;
          res_handle = req_handle;
        end
      end
      default: begin
        state_next = hlbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == hlbc_pkg::S_IDLE && req_valid) begin
      req_cmd    <= cmd;
      req_device <= device;
      req_block  <= block_number;
      req_handle <= handle_in;
    end
    if (state == hlbc_pkg::S_MOD && rem_done) begin
      base       <= hlbc_pkg::IDX_W'(rem_bucket) * hlbc_pkg::IDX_W'(hlbc_pkg::WAYS);
      way        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == hlbc_pkg::S_SCAN) begin
      if (tag_match && (!hit_found || rd_ent.rank > hit_ent.rank)) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_ent   <= rd_ent;
      end
      if (rd_ent.count == '0 && (!free_found || rd_ent.rank < free_rank)) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
        free_rank  <= rd_ent.rank;
      end
      way <= way + 1'b1;
    end
    if (go_rank) begin
      base    <= hlbc_pkg::IDX_W'(req_handle) -
                 hlbc_pkg::IDX_W'(hlbc_pkg::handle_way(req_handle));
      way     <= '0;
      mr_rank <= rd_ent.rank;
    end
    if (state == hlbc_pkg::S_RANK && wr.en) begin
      way <= way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res_status;
      handle_out <= res_handle;
      hit        <= res_hit;
      needs_read <= res_read;
    end
  end

endmodule
